// ===== src/max_submatrix_sum_bounded_macros.svh =====
// ----------------------------------------------------------------------------
// max_submatrix_sum_bounded_macros
// assertion macros shared by the port checker of the bounded submatrix search
// ----------------------------------------------------------------------------
`ifndef MAX_SUBMATRIX_SUM_BOUNDED_MACROS_SVH
`define MAX_SUBMATRIX_SUM_BOUNDED_MACROS_SVH

// consequent checked in the same cycle, masked during reset
`define MSSB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed");

// consequent checked in the next cycle, masked during reset
`define MSSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed");

// state seen on the ports in the cycle after a reset cycle
`define MSSB_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("reset state check failed");

`endif

// ===== src/mssb_pkg.sv =====
// ----------------------------------------------------------------------------
// mssb_pkg
// shared types and constants of the bounded submatrix sum search
// ----------------------------------------------------------------------------
package mssb_pkg;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int COUNT_REG_BITS = 5;
   localparam int BOUND_BITS     = 32;
   localparam int RESULT_BITS    = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROW_COUNT    = 2'd0,
      CSR_COLUMN_COUNT = 2'd1,
      CSR_SUM_BOUND    = 2'd2
   } csr_index_type;

   localparam logic [COUNT_REG_BITS-1:0] ROW_COUNT_RESET    = 5'd16;
   localparam logic [COUNT_REG_BITS-1:0] COLUMN_COUNT_RESET = 5'd16;
   localparam logic [BOUND_BITS-1:0]     SUM_BOUND_RESET    = 32'd0;

   // queue between front and back
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;

   // what the front decided about one item
   typedef struct packed {
      logic store;
      logic last;
   } item_flags_type;

   // search sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ACCUM,
      BK_DRAIN,
      BK_SCAN,
      BK_FINISH
   } back_state_type;

endpackage

// ===== src/max_submatrix_sum_bounded.sv =====
// ----------------------------------------------------------------------------
// max_submatrix_sum_bounded
// Loads a signed matrix in row-major order, one element per start taken
// while busy is low, and after the element marked last reports the largest
// sum of any rectangle that does not exceed sum_bound, with a found flag
// (best_sum is zero when nothing fits). Elements go into a four-entry queue
// and are written to the matrix store at one per cycle while no search
// runs, so loading runs at one element per clock while busy is low.
// The search after the last element is paced by the single read port of
// the row-sum memory: for each of C(C+1)/2 column pairs it builds the R
// row sums and then scans the R(R+1)/2 row runs, then finishes and reports.
// busy rises once the queue fills behind a running search. The result is a
// single-cycle strobe on rsp_valid and cannot be held off by the receiver.
// Row and column counts of zero act as one, counts above the maximum act as
// the maximum; elements past the configured size are dropped.
// ----------------------------------------------------------------------------
module max_submatrix_sum_bounded import mssb_pkg::*; #(
   parameter int MAX_ROWS  = 16,
   parameter int MAX_COLS  = 16,
   parameter int ELEM_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [ELEM_BITS-1:0]   req_element,
   input  logic                          req_last,
   output logic                          rsp_valid,
   output logic signed [RESULT_BITS-1:0] rsp_best_sum,
   output logic                          rsp_found,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int QW    = $bits(item_flags_type) + AW + ELEM_BITS + RW + CW + BOUND_BITS;

   logic                         push_valid;
   item_flags_type               push_flags;
   logic [AW-1:0]                push_addr;
   logic signed [ELEM_BITS-1:0]  push_element;
   logic [RW-1:0]                push_rows_last;
   logic [CW-1:0]                push_cols_last;
   logic signed [BOUND_BITS-1:0] push_bound;
   logic [QW-1:0]                push_data;

   logic                         pop_valid;
   logic                         pop_ready;
   logic [QW-1:0]                pop_data;
   item_flags_type               pop_flags;
   logic [AW-1:0]                pop_addr;
   logic signed [ELEM_BITS-1:0]  pop_element;
   logic [RW-1:0]                pop_rows_last;
   logic [CW-1:0]                pop_cols_last;
   logic signed [BOUND_BITS-1:0] pop_bound;
   logic                         queue_full;

   // accept and classify
   mssb_front #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .ELEM_BITS (ELEM_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_element    (req_element),
      .req_last       (req_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .push_valid     (push_valid),
      .push_flags     (push_flags),
      .push_addr      (push_addr),
      .push_element   (push_element),
      .push_rows_last (push_rows_last),
      .push_cols_last (push_cols_last),
      .push_bound     (push_bound)
   );

   // queue entry layout
   assign push_data = {push_flags, push_addr, push_element, push_rows_last,
                       push_cols_last, push_bound};
   assign {pop_flags, pop_addr, pop_element, pop_rows_last,
           pop_cols_last, pop_bound} = pop_data;

   mssb_queue #(
      .DATA_BITS (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign busy = queue_full;

   // store and search
   mssb_back #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .ELEM_BITS (ELEM_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_flags     (pop_flags),
      .pop_addr      (pop_addr),
      .pop_element   (pop_element),
      .pop_rows_last (pop_rows_last),
      .pop_cols_last (pop_cols_last),
      .pop_bound     (pop_bound),
      .rsp_valid     (rsp_valid),
      .rsp_best_sum  (rsp_best_sum),
      .rsp_found     (rsp_found)
   );

endmodule

// ===== src/mssb_front.sv =====
// ----------------------------------------------------------------------------
// mssb_front
// configuration registers, load position tracking and item classification
// ----------------------------------------------------------------------------
module mssb_front import mssb_pkg::*; #(
   parameter int MAX_ROWS  = 16,
   parameter int MAX_COLS  = 16,
   parameter int ELEM_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    busy,
   input  logic signed [ELEM_BITS-1:0]             req_element,
   input  logic                                    req_last,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0]                csr_wdata,
   output logic                                    push_valid,
   output item_flags_type                          push_flags,
   output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] push_addr,
   output logic signed [ELEM_BITS-1:0]             push_element,
   output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] push_rows_last,
   output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] push_cols_last,
   output logic signed [BOUND_BITS-1:0]            push_bound
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = $clog2(DEPTH + 1);
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RCW   = RW + 1;
   localparam int CCW   = CW + 1;

   logic [COUNT_REG_BITS-1:0]  row_count_ff, row_count_in;
   logic [COUNT_REG_BITS-1:0]  column_count_ff, column_count_in;
   logic signed [BOUND_BITS-1:0] sum_bound_ff, sum_bound_in;
   logic [LW-1:0]              load_index_ff, load_index_in;
   logic [RCW-1:0]             rows_cnt;
   logic [CCW-1:0]             cols_cnt;
   logic [RCW+CCW-1:0]         cell_product;
   logic [LW-1:0]              total;
   logic                       accept;
   logic                       store;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      sum_bound_in    = sum_bound_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROW_COUNT:    row_count_in    = csr_wdata[COUNT_REG_BITS-1:0];
            CSR_COLUMN_COUNT: column_count_in = csr_wdata[COUNT_REG_BITS-1:0];
            CSR_SUM_BOUND:    sum_bound_in    = csr_wdata[BOUND_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamp counts into one..max
   always_comb begin
      if (row_count_ff == '0) begin
         rows_cnt = RCW'(1);
      end else if (32'(row_count_ff) > MAX_ROWS) begin
         rows_cnt = RCW'(MAX_ROWS);
      end else begin
         rows_cnt = RCW'(row_count_ff);
      end
      if (column_count_ff == '0) begin
         cols_cnt = CCW'(1);
      end else if (32'(column_count_ff) > MAX_COLS) begin
         cols_cnt = CCW'(MAX_COLS);
      end else begin
         cols_cnt = CCW'(column_count_ff);
      end
   end

   assign cell_product = rows_cnt * cols_cnt;
   assign total        = LW'(cell_product);

   // classify the item: stored while the matrix is not yet full
   assign accept = start && !busy;
   assign store  = (load_index_ff < total);

   always_comb begin
      load_index_in = load_index_ff;
      if (accept) begin
         if (req_last) begin
            load_index_in = '0;
         end else if (store) begin
            load_index_in = load_index_ff + LW'(1);
         end
      end
   end

   assign push_valid       = accept;
   assign push_flags.store = store;
   assign push_flags.last  = req_last;
   assign push_addr        = load_index_ff[AW-1:0];
   assign push_element     = req_element;
   assign push_rows_last   = RW'(rows_cnt - RCW'(1));
   assign push_cols_last   = CW'(cols_cnt - CCW'(1));
   assign push_bound       = sum_bound_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_COUNT_RESET;
         column_count_ff <= COLUMN_COUNT_RESET;
         sum_bound_ff    <= SUM_BOUND_RESET;
         load_index_ff   <= '0;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         sum_bound_ff    <= sum_bound_in;
         load_index_ff   <= load_index_in;
      end
   end

endmodule

// ===== src/mssb_queue.sv =====
// ----------------------------------------------------------------------------
// mssb_queue
// short first-in first-out queue between item classification and search
// ----------------------------------------------------------------------------
module mssb_queue import mssb_pkg::*; #(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output logic [DATA_BITS-1:0] pop_data
);

   logic [DATA_BITS-1:0]      entries [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      pop_fire;

   assign full      = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries[rd_ptr_ff];
   assign pop_fire  = pop_valid && pop_ready;

   // pointers wrap on their own since the depth is a power of two
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_BITS+1)'(push_valid)
                  - (QUEUE_PTR_BITS+1)'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/mssb_back.sv =====
// ----------------------------------------------------------------------------
// mssb_back
// matrix store and the rectangle search sequencer with its result register
// ----------------------------------------------------------------------------
module mssb_back import mssb_pkg::*; #(
   parameter int MAX_ROWS  = 16,
   parameter int MAX_COLS  = 16,
   parameter int ELEM_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    pop_valid,
   output logic                                    pop_ready,
   input  item_flags_type                          pop_flags,
   input  logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] pop_addr,
   input  logic signed [ELEM_BITS-1:0]             pop_element,
   input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] pop_rows_last,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] pop_cols_last,
   input  logic signed [BOUND_BITS-1:0]            pop_bound,
   output logic                                    rsp_valid,
   output logic signed [RESULT_BITS-1:0]           rsp_best_sum,
   output logic                                    rsp_found
);

   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int SUM_BITS = ELEM_BITS + $clog2(DEPTH) + 1;
   localparam int WIDE     = (SUM_BITS > RESULT_BITS) ? SUM_BITS : RESULT_BITS;

   // memories
   logic signed [ELEM_BITS-1:0] matrix_mem [DEPTH];
   logic signed [SUM_BITS-1:0]  rsum_mem [MAX_ROWS];
   logic signed [ELEM_BITS-1:0] mat_q_ff;
   logic signed [SUM_BITS-1:0]  rs_q_ff;
   logic [RW-1:0]               rs_raddr;
   logic signed [SUM_BITS-1:0]  mat_ext;
   logic signed [SUM_BITS-1:0]  rs_wdata;

   // sequencer
   back_state_type              state_ff, state_in;
   logic [RW-1:0]               rows_last_ff, rows_last_in;
   logic [CW-1:0]               cols_last_ff, cols_last_in;
   logic signed [BOUND_BITS-1:0] bound_ff, bound_in;
   logic [CW-1:0]               left_ff, left_in;
   logic [CW-1:0]               right_ff, right_in;
   logic [RW-1:0]               row_ff, row_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [RW-1:0]               top_ff, top_in;
   logic [RW-1:0]               bottom_ff, bottom_in;
   logic [AW:0]                 addr_step;
   logic [CW-1:0]               left_plus;
   logic [CW-1:0]               right_plus;
   logic                        pop_fire;
   logic                        start_search;

   // pipeline stages behind the memory reads
   logic                        acc_v_ff, acc_v_in;
   logic [RW-1:0]               acc_row_ff, acc_row_in;
   logic                        acc_first_ff, acc_first_in;
   logic                        scan_v_ff, scan_v_in;
   logic                        scan_first_ff, scan_first_in;
   logic                        cmp_v_ff, cmp_v_in;

   // running and best sums
   logic signed [SUM_BITS-1:0]  running_ff, running_in;
   logic signed [SUM_BITS-1:0]  best_ff, best_in;
   logic                        best_valid_ff, best_valid_in;
   logic signed [WIDE-1:0]      run_w;
   logic signed [WIDE-1:0]      best_w;
   logic signed [WIDE-1:0]      bound_w;
   logic                        hit;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_BITS-1:0] rsp_best_sum_ff, rsp_best_sum_in;
   logic                        rsp_found_ff, rsp_found_in;

   assign pop_ready = (state_ff == BK_IDLE);
   assign pop_fire  = pop_valid && pop_ready;

   // matrix store: one write port from the queue, one read port for the search
   always_ff @(posedge clock) begin
      if (pop_fire && pop_flags.store) begin
         matrix_mem[pop_addr] <= pop_element;
      end
      mat_q_ff <= matrix_mem[addr_ff];
   end

   // row sums over the current column span
   assign rs_raddr = (state_ff == BK_ACCUM) ? row_ff : bottom_ff;
   assign mat_ext  = SUM_BITS'(mat_q_ff);
   assign rs_wdata = acc_first_ff ? mat_ext : rs_q_ff + mat_ext;

   always_ff @(posedge clock) begin
      if (acc_v_ff) begin
         rsum_mem[acc_row_ff] <= rs_wdata;
      end
      rs_q_ff <= rsum_mem[rs_raddr];
   end

   // address of the next row in the same column
   assign addr_step  = {1'b0, addr_ff} + (AW+1)'(cols_last_ff) + (AW+1)'(1);
   assign left_plus  = CW'(left_ff + 1'b1);
   assign right_plus = CW'(right_ff + 1'b1);

   // search sequencer: column pairs, row accumulation, then row runs
   always_comb begin
      state_in        = state_ff;
      rows_last_in    = rows_last_ff;
      cols_last_in    = cols_last_ff;
      bound_in        = bound_ff;
      left_in         = left_ff;
      right_in        = right_ff;
      row_in          = row_ff;
      addr_in         = addr_ff;
      top_in          = top_ff;
      bottom_in       = bottom_ff;
      acc_v_in        = 1'b0;
      acc_row_in      = row_ff;
      acc_first_in    = (right_ff == left_ff);
      scan_v_in       = 1'b0;
      scan_first_in   = (bottom_ff == top_ff);
      start_search    = 1'b0;
      rsp_valid_in    = 1'b0;
      rsp_best_sum_in = rsp_best_sum_ff;
      rsp_found_in    = rsp_found_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid && pop_flags.last) begin
               start_search = 1'b1;
               rows_last_in = pop_rows_last;
               cols_last_in = pop_cols_last;
               bound_in     = pop_bound;
               left_in      = '0;
               right_in     = '0;
               row_in       = '0;
               addr_in      = '0;
               state_in     = BK_ACCUM;
            end
         end
         BK_ACCUM: begin
            acc_v_in = 1'b1;
            if (row_ff == rows_last_ff) begin
               state_in = BK_DRAIN;
            end else begin
               row_in  = row_ff + RW'(1);
               addr_in = addr_step[AW-1:0];
            end
         end
         BK_DRAIN: begin
            // last row sum lands before the scan reads it
            top_in    = '0;
            bottom_in = '0;
            state_in  = BK_SCAN;
         end
         BK_SCAN: begin
            scan_v_in = 1'b1;
            if (bottom_ff == rows_last_ff) begin
               if (top_ff == rows_last_ff) begin
                  row_in = '0;
                  if (right_ff == cols_last_ff) begin
                     if (left_ff == cols_last_ff) begin
                        state_in = BK_FINISH;
                     end else begin
                        left_in  = left_plus;
                        right_in = left_plus;
                        addr_in  = AW'(left_plus);
                        state_in = BK_ACCUM;
                     end
                  end else begin
                     right_in = right_plus;
                     addr_in  = AW'(right_plus);
                     state_in = BK_ACCUM;
                  end
               end else begin
                  top_in    = top_ff + RW'(1);
                  bottom_in = top_ff + RW'(1);
               end
            end else begin
               bottom_in = bottom_ff + RW'(1);
            end
         end
         BK_FINISH: begin
            // wait for the last compare before reporting
            if (!scan_v_ff && !cmp_v_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_best_sum_in = best_valid_ff ? best_w[RESULT_BITS-1:0] : '0;
               rsp_found_in    = best_valid_ff;
               state_in        = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // run of rows: add then compare one stage later
   assign run_w   = WIDE'(running_ff);
   assign best_w  = WIDE'(best_ff);
   assign bound_w = WIDE'(bound_ff);
   assign hit     = (run_w <= bound_w) && (!best_valid_ff || (run_w > best_w));

   always_comb begin
      running_in    = running_ff;
      cmp_v_in      = scan_v_ff;
      best_in       = best_ff;
      best_valid_in = best_valid_ff;
      if (scan_v_ff) begin
         running_in = (scan_first_ff ? '0 : running_ff) + rs_q_ff;
      end
      if (start_search) begin
         best_in       = '0;
         best_valid_in = 1'b0;
      end else if (cmp_v_ff && hit) begin
         best_in       = running_ff;
         best_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         acc_v_ff      <= 1'b0;
         scan_v_ff     <= 1'b0;
         cmp_v_ff      <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_v_ff      <= acc_v_in;
         scan_v_ff     <= scan_v_in;
         cmp_v_ff      <= cmp_v_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      rows_last_ff    <= rows_last_in;
      cols_last_ff    <= cols_last_in;
      bound_ff        <= bound_in;
      left_ff         <= left_in;
      right_ff        <= right_in;
      row_ff          <= row_in;
      addr_ff         <= addr_in;
      top_ff          <= top_in;
      bottom_ff       <= bottom_in;
      acc_row_ff      <= acc_row_in;
      acc_first_ff    <= acc_first_in;
      scan_first_ff   <= scan_first_in;
      running_ff      <= running_in;
      best_ff         <= best_in;
      rsp_best_sum_ff <= rsp_best_sum_in;
      rsp_found_ff    <= rsp_found_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_sum = rsp_best_sum_ff;
   assign rsp_found    = rsp_found_ff;

endmodule

// ===== src/mssb_checker.sv =====
// ----------------------------------------------------------------------------
// mssb_checker
// port level checks of the bounded submatrix search, bound to the top level
// ----------------------------------------------------------------------------
`include "max_submatrix_sum_bounded_macros.svh"

module mssb_checker import mssb_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic signed [RESULT_BITS-1:0] rsp_best_sum,
   input logic                          rsp_found
);

   // every search runs through the accumulate, drain, scan and finish states, so strobes never touch
   `MSSB_ASSERT_NEXT(a_rsp_single_cycle, clock, reset, rsp_valid, !rsp_valid)

   // nothing within bound reports a zero sum
   `MSSB_ASSERT_SAME(a_not_found_zero, clock, reset, rsp_valid && !rsp_found, rsp_best_sum == '0)

   // reset leaves the queue empty and no result pending
   `MSSB_ASSERT_AFTER_RESET(a_reset_quiet, clock, reset, !busy && !rsp_valid)

endmodule

bind max_submatrix_sum_bounded mssb_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_best_sum (rsp_best_sum),
   .rsp_found    (rsp_found)
);

// ===== tb/tb_max_submatrix_sum_bounded.sv =====
// ----------------------------------------------------------------------------
// tb_max_submatrix_sum_bounded
// Self-checking bench for the bounded submatrix sum search. A short table of
// hand-picked matrices and register writes runs first: extreme elements and
// bounds, clamped counts, extra and missing elements, and a size change in
// the middle of a load. Randomly sized matrices with random content follow,
// mostly complete and some short or overlong. Every result is checked
// against the answer typed in the table where it has one, else against a
// predictor redoing the search on its own copy of the store and registers.
// ----------------------------------------------------------------------------
module tb_max_submatrix_sum_bounded;
   import mssb_pkg::*;

   localparam int MAX_ROWS     = 16;
   localparam int MAX_COLS     = 16;
   localparam int ELEM_BITS    = 16;
   localparam int STORE_DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int RANDOM_ITEMS = 750;
   localparam int CALM_ITEMS   = 100;
   localparam int DRAIN_PAUSE  = 16;
   localparam int TAIL_CYCLES  = 64;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int REPORT_LIMIT = 10;
   localparam int LARGE_SIZES  = 4;

   // index with no register behind it, writes to it are dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic signed [RESULT_BITS-1:0] best_sum;
      logic                          found;
   } rect_result_type;

   // per last-marked element: whether the table gives the answer by hand
   typedef struct {
      bit              typed;
      rect_result_type want;
   } hand_check_type;

   typedef enum logic {PLAN_REG, PLAN_ELEM} plan_kind_type;

   typedef struct {
      plan_kind_type                 kind;
      logic [CSR_INDEX_BITS-1:0]     index;
      logic [CSR_DATA_BITS-1:0]      data;
      logic signed [ELEM_BITS-1:0]   element;
      logic                          last;
      bit                            typed;
      rect_result_type               want;
   } plan_row_type;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          start       = 1'b0;
   logic                          busy;
   logic signed [ELEM_BITS-1:0]   req_element = '0;
   logic                          req_last    = 1'b0;
   logic                          rsp_valid;
   logic signed [RESULT_BITS-1:0] rsp_best_sum;
   logic                          rsp_found;
   logic                          csr_valid   = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata   = '0;

   // predictor copy of the block
   logic signed [ELEM_BITS-1:0]   store_mem [STORE_DEPTH];
   int                            load_pos  = 0;
   logic [COUNT_REG_BITS-1:0]     rows_reg  = ROW_COUNT_RESET;
   logic [COUNT_REG_BITS-1:0]     cols_reg  = COLUMN_COUNT_RESET;
   logic signed [BOUND_BITS-1:0]  bound_reg = SUM_BOUND_RESET;

   rect_result_type best_rect_q [$];
   hand_check_type  hand_q [$];
   int              mismatch_count = 0;

   // stimulus-side view of the load position and of store coverage
   logic [COUNT_REG_BITS-1:0] gen_rows_raw = ROW_COUNT_RESET;
   logic [COUNT_REG_BITS-1:0] gen_cols_raw = COLUMN_COUNT_RESET;
   int                        gen_pos      = 0;
   bit                        ever_loaded [STORE_DEPTH];
   int                        items_stored = 0;

   plan_row_type stim_plan [$];

   max_submatrix_sum_bounded #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .ELEM_BITS (ELEM_BITS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_element  (req_element),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_best_sum (rsp_best_sum),
      .rsp_found    (rsp_found),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic int clamp_count(input logic [COUNT_REG_BITS-1:0] raw, input int limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return raw;
   endfunction

   function automatic int gen_total();
      return clamp_count(gen_rows_raw, MAX_ROWS) * clamp_count(gen_cols_raw, MAX_COLS);
   endfunction

   // exhaustive rectangle search over the predictor store
   function automatic rect_result_type search_best_rect(input int rows, input int cols,
                                                        input longint bound);
      rect_result_type res;
      longint          strip [MAX_ROWS];
      longint          run;
      longint          best;
      bit              hit;
      best = 0;
      hit  = 1'b0;
      for (int lc = 0; lc < cols; lc++) begin
         for (int r = 0; r < MAX_ROWS; r++) strip[r] = 0;
         for (int rc = lc; rc < cols; rc++) begin
            for (int r = 0; r < rows; r++) strip[r] += store_mem[r * cols + rc];
            for (int top = 0; top < rows; top++) begin
               run = 0;
               for (int bot = top; bot < rows; bot++) begin
                  run += strip[bot];
                  if (run <= bound && (!hit || run > best)) begin
                     best = run;
                     hit  = 1'b1;
                  end
               end
            end
         end
      end
      res.best_sum = hit ? best[RESULT_BITS-1:0] : '0;
      res.found    = hit;
      return res;
   endfunction

   task automatic note_mismatch(input string what, input rect_result_type want,
                                input rect_result_type got);
      if (mismatch_count < REPORT_LIMIT)
         $display("mismatch (%s): best_sum exp %0d got %0d, found exp %0b got %0b",
                  what, want.best_sum, got.best_sum, want.found, got.found);
      mismatch_count++;
   endtask

   // scoreboard: results, element transfers and register transfers
   always @(posedge clock) begin
      rect_result_type got;
      rect_result_type want;
      hand_check_type  hand;
      int              rows;
      int              cols;
      if (!reset) begin
         // result transfer against the oldest expectation
         if (rsp_valid) begin
            got.best_sum = rsp_best_sum;
            got.found    = rsp_found;
            if (best_rect_q.size() == 0) begin
               want.best_sum = '0;
               want.found    = 1'b0;
               note_mismatch("no result pending", want, got);
            end else begin
               want = best_rect_q.pop_front();
               hand = hand_q.pop_front();
               if (hand.typed) want = hand.want;
               if (got.best_sum !== want.best_sum || got.found !== want.found)
                  note_mismatch("wrong result", want, got);
            end
         end
         // element transfer, store and maybe search
         if (start && !busy) begin
            rows = clamp_count(rows_reg, MAX_ROWS);
            cols = clamp_count(cols_reg, MAX_COLS);
            if (load_pos < rows * cols) begin
               store_mem[load_pos] = req_element;
               load_pos++;
            end
            if (req_last) begin
               best_rect_q.push_back(search_best_rect(rows, cols, bound_reg));
               load_pos = 0;
            end
         end
         // register transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_COUNT:    rows_reg  = csr_wdata[COUNT_REG_BITS-1:0];
               CSR_COLUMN_COUNT: cols_reg  = csr_wdata[COUNT_REG_BITS-1:0];
               CSR_SUM_BOUND:    bound_reg = csr_wdata[BOUND_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // register write, only once all results are in and the queue has drained
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      start <= 1'b0;
      while (hand_q.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ROW_COUNT) gen_rows_raw = data[COUNT_REG_BITS-1:0];
      if (idx == CSR_COLUMN_COUNT) gen_cols_raw = data[COUNT_REG_BITS-1:0];
   endtask

   // one element transfer; start is left high for the caller to decide
   task automatic send_item(input logic signed [ELEM_BITS-1:0] elem, input logic last_flag,
                            input bit typed, input rect_result_type want);
      hand_check_type hc;
      if (last_flag) begin
         hc.typed = typed;
         hc.want  = want;
         hand_q.push_back(hc);
      end
      start       <= 1'b1;
      req_element <= elem;
      req_last    <= last_flag;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gen_pos < gen_total()) begin
         ever_loaded[gen_pos] = 1'b1;
         gen_pos++;
         items_stored++;
      end
      if (last_flag) gen_pos = 0;
   endtask

   function automatic void plan_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                    input logic [CSR_DATA_BITS-1:0] data);
      plan_row_type row;
      row = '{kind: PLAN_REG, index: idx, data: data, element: '0, last: 1'b0,
              typed: 1'b0, want: '{best_sum: '0, found: 1'b0}};
      stim_plan.push_back(row);
   endfunction

   function automatic void plan_elem(input logic signed [ELEM_BITS-1:0] elem,
                                     input logic last_flag);
      plan_row_type row;
      row = '{kind: PLAN_ELEM, index: '0, data: '0, element: elem, last: last_flag,
              typed: 1'b0, want: '{best_sum: '0, found: 1'b0}};
      stim_plan.push_back(row);
   endfunction

   // last element with the answer given by hand
   function automatic void plan_checked(input logic signed [ELEM_BITS-1:0] elem,
                                        input logic signed [RESULT_BITS-1:0] sum,
                                        input logic found);
      plan_row_type row;
      row = '{kind: PLAN_ELEM, index: '0, data: '0, element: elem, last: 1'b1,
              typed: 1'b1, want: '{best_sum: sum, found: found}};
      stim_plan.push_back(row);
   endfunction

   initial begin
      rect_result_type             no_want;
      logic signed [ELEM_BITS-1:0] elem;
      logic [CSR_DATA_BITS-1:0]    word;
      logic [COUNT_REG_BITS-1:0]   raw;
      int                          total;
      int                          n;
      int                          v;
      int                          elem_mode;
      int                          large_left;
      int                          rand_start;
      bit                          covered;
      bit                          gap_mode;
      bit                          calm;
      bit                          large_now;

      no_want.best_sum = '0;
      no_want.found    = 1'b0;
      large_left       = LARGE_SIZES;

      // clamped counts: 31 rows act as 16, 0 columns act as 1
      plan_reg(CSR_ROW_COUNT, 32'd31);
      plan_reg(CSR_COLUMN_COUNT, 32'd0);
      plan_reg(CSR_SUM_BOUND, 32'd20);
      plan_reg(CSR_SPARE, 32'hFFFF_FFFF);
      for (int k = 0; k < 16; k++)
         plan_elem(ELEM_BITS'((k % 3 == 0) ? -32768 : (k % 3 == 1) ? 32767 : k), k == 15);
      // single element at the extremes
      plan_reg(CSR_ROW_COUNT, 32'd1);
      plan_reg(CSR_COLUMN_COUNT, 32'd1);
      plan_reg(CSR_SUM_BOUND, 32'd0);
      plan_checked(-32768, -32768, 1'b1);
      // nothing within bound
      plan_checked(32767, 0, 1'b0);
      // extra elements past the matrix, last one still starts the search
      plan_reg(CSR_SUM_BOUND, 32'h7FFF_FFFF);
      plan_reg(CSR_ROW_COUNT, 32'd0);
      plan_reg(CSR_COLUMN_COUNT, 32'd2);
      plan_elem(5, 1'b0);
      plan_elem(-3, 1'b0);
      plan_elem(7, 1'b0);
      plan_checked(9, 5, 1'b1);
      // lowest bound: every sum is above it
      plan_reg(CSR_SUM_BOUND, 32'h8000_0000);
      plan_elem(-32768, 1'b0);
      plan_checked(-32768, 0, 1'b0);
      // sum below the old sentinel, one element short of the matrix
      plan_reg(CSR_SUM_BOUND, 32'hFFFF_0000);
      plan_checked(-32768, -65536, 1'b1);
      // size grows in the middle of a load
      plan_reg(CSR_SUM_BOUND, 32'h7FFF_FFFF);
      plan_reg(CSR_COLUMN_COUNT, 32'd2);
      plan_elem(100, 1'b0);
      plan_reg(CSR_COLUMN_COUNT, 32'd3);
      plan_elem(200, 1'b0);
      plan_checked(300, 600, 1'b1);
      // short matrix on entries left from earlier loads
      plan_reg(CSR_ROW_COUNT, 32'd4);
      plan_reg(CSR_COLUMN_COUNT, 32'd4);
      plan_reg(CSR_SUM_BOUND, 32'd0);
      plan_elem(1, 1'b1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (stim_plan[i]) begin
         if (stim_plan[i].kind == PLAN_REG) begin
            write_reg(stim_plan[i].index, stim_plan[i].data);
         end else begin
            send_item(stim_plan[i].element, stim_plan[i].last, stim_plan[i].typed,
                      stim_plan[i].want);
         end
      end

      // random matrices
      rand_start = items_stored;
      while (items_stored - rand_start < RANDOM_ITEMS) begin
         calm      = (items_stored - rand_start) >= RANDOM_ITEMS - CALM_ITEMS;
         large_now = gen_total() > 32;
         // new sizes now and then, always after a large matrix
         if (large_now || $urandom_range(0, 2) == 0) begin
            if (large_now || $urandom_range(0, 1)) begin
               if (large_left > 0 && $urandom_range(0, 24) == 0) begin
                  word = $urandom_range(16, 31);
                  large_left--;
               end else begin
                  word = $urandom_range(0, 4);
               end
               raw = word[COUNT_REG_BITS-1:0];
               write_reg(CSR_ROW_COUNT, ($urandom() & 32'hFFFF_FFE0) | raw);
            end
            if (large_now || $urandom_range(0, 1)) begin
               if (large_left > 0 && $urandom_range(0, 24) == 0) begin
                  word = $urandom_range(16, 31);
                  large_left--;
               end else begin
                  word = $urandom_range(0, 4);
               end
               raw = word[COUNT_REG_BITS-1:0];
               write_reg(CSR_COLUMN_COUNT, ($urandom() & 32'hFFFF_FFE0) | raw);
            end
            if ($urandom_range(0, 1)) begin
               case ($urandom_range(0, 5))
                  0: word = $urandom();
                  1: begin
                     v    = $urandom_range(0, 2000);
                     word = v - 1000;
                  end
                  2: begin
                     v    = $urandom_range(0, 600000);
                     word = v - 300000;
                  end
                  3: word = 32'h8000_0000;
                  4: word = 32'h7FFF_FFFF;
                  default: word = '0;
               endcase
               write_reg(CSR_SUM_BOUND, word);
            end
            if ($urandom_range(0, 29) == 0) write_reg(CSR_SPARE, $urandom());
         end

         // mostly complete matrices, some overlong, some short
         total = gen_total();
         n     = total;
         case ($urandom_range(0, 9))
            7, 8: n = total + $urandom_range(1, 3);
            9: begin
               covered = 1'b1;
               for (int i = 0; i < total; i++) if (!ever_loaded[i]) covered = 1'b0;
               if (covered && total > 1) n = $urandom_range(1, total - 1);
            end
            default: ;
         endcase

         elem_mode = $urandom_range(0, 2);
         gap_mode  = !calm && $urandom_range(0, 1);
         for (int k = 0; k < n; k++) begin
            // idle burst on the sending side
            if (gap_mode && $urandom_range(0, 3) == 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 11)) @(posedge clock);
            end
            case (elem_mode)
               0: begin
                  word = $urandom();
                  elem = word[ELEM_BITS-1:0];
               end
               1: begin
                  v    = $urandom_range(0, 40);
                  v    = v - 20;
                  elem = v[ELEM_BITS-1:0];
               end
               default: begin
                  case ($urandom_range(0, 3))
                     0: elem = 16'sh8000;
                     1: elem = 16'sh7FFF;
                     2: elem = '0;
                     default: elem = -1;
                  endcase
               end
            endcase
            send_item(elem, k == n - 1, 1'b0, no_want);
         end
      end
      start <= 1'b0;

      // drain and settle
      while (hand_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && best_rect_q.size() == 0) begin
         $display("max_submatrix_sum_bounded test passed");
      end else begin
         $display("max_submatrix_sum_bounded test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("max_submatrix_sum_bounded test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/mssb_pkg.sv
src/mssb_front.sv
src/mssb_queue.sv
src/mssb_back.sv
src/max_submatrix_sum_bounded.sv
src/mssb_checker.sv
tb/tb_max_submatrix_sum_bounded.sv
